>>> rtl/afd_pkg.sv
// Package for the frame deframer: the queue item type, parser phases and constants.
// Used by every module of the block; depends on nothing.
package afd_pkg;

    localparam int BUFFER_BYTES = 128;
    localparam int IO_BYTE_POS  = 17;

    localparam logic [7:0] DELIM_BYTE = 8'h7E;
    localparam logic [7:0] SUM_GOOD   = 8'hFF;
    localparam logic [7:0] TYPE_IO    = 8'h82;
    localparam logic [7:0] IO_ON      = 8'h01;

    localparam logic [1:0] CFG_QUIET_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_LINK_WORRY    = 2'd1;

    typedef enum logic [1:0] {
        PH_SEEK = 2'd0,
        PH_SIZE = 2'd1,
        PH_DATA = 2'd2,
        PH_CKSM = 2'd3
    } phase_t;

    // One classified request as it waits between front and back end.
    typedef struct packed {
        logic        is_byte;
        logic [7:0]  rx_byte;
        logic [31:0] now_ms;
        logic        gap;
        logic        is_delim;
        logic        is_type;
        logic        is_one;
        logic        now_lt_worry;
    } afd_item_t;

endpackage

>>> rtl/api_frame_deframer_checksum.sv
// Top level of the delimiter, length and checksum frame deframer with link watchdog.
// Depends on afd_pkg, afd_front, afd_queue and afd_back.
//
// Each request on the slave stream is either a received serial byte (s_tuser low) or a
// status query (s_tuser high); both carry a millisecond timestamp. Frames open with 0x7E,
// carry a big-endian 16-bit length, that many data bytes (at least one) and a checksum
// byte; the 8-bit sum of data and checksum equal to 0xFF marks a good frame. A byte that
// arrives after a quiet gap of quiet_timeout_ms or more, or once the frame has run past
// the buffer size, restarts the hunt for the delimiter. Every request yields exactly one
// result, which reports frame_good, frame_bad, alarm_ack (a good frame of type 0x82 whose
// input byte inside the same frame is 0x01) and link_up. The block takes one request per
// clock cycle in steady flow; an accepted request passes through the queue and then the
// output register before m_tvalid rises with its result.
// The rate is set by the parser update in the back end, which settles one byte per cycle.
// A small queue between the classifying front end and the parser, and the output register,
// let either stream side stall without stopping the other for QUEUE_DEPTH requests.
// Configuration writes are always taken and are meant to happen only while the block is idle.
module api_frame_deframer_checksum #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // rx_byte [7:0], now_ms [39:8]
    input  logic        s_tuser,    // req_type [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // frame_good [0], frame_bad [1], alarm_ack [2],
                                    // link_up [3], zero [7:4]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [15:0] quiet_timeout_reg;
    logic [31:0] link_worry_reg;
    logic        push;
    logic        pop;
    logic        item_valid;
    logic [3:0]  result;
    afd_pkg::afd_item_t push_item;
    afd_pkg::afd_item_t pop_item;

    // Writes are taken in every cycle; indexes beyond the register list are ignored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quiet_timeout_reg <= 16'd10;
            link_worry_reg    <= 32'd150000;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == afd_pkg::CFG_QUIET_TIMEOUT) begin
                quiet_timeout_reg <= cfg_data[15:0];
            end
            if (cfg_index == afd_pkg::CFG_LINK_WORRY) begin
                link_worry_reg <= cfg_data;
            end
        end
    end

    // The front end owns the byte clock, so the quiet gap is known before queueing.
    afd_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (s_tvalid),
        .queue_ready      (s_tready),
        .req_type         (s_tuser),
        .rx_byte          (s_tdata[7:0]),
        .now_ms           (s_tdata[39:8]),
        .quiet_timeout_ms (quiet_timeout_reg),
        .link_worry_ms    (link_worry_reg),
        .push             (push),
        .item             (push_item)
    );

    afd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_item  (push_item),
        .push_ready (s_tready),
        .pop        (pop),
        .pop_valid  (item_valid),
        .pop_item   (pop_item)
    );

    // The back end runs the parser and holds the result until the master side takes it.
    afd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item_valid    (item_valid),
        .item          (pop_item),
        .pop           (pop),
        .link_worry_ms (link_worry_reg),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_data      (result)
    );

    assign m_tdata = {4'd0, result};

endmodule

>>> rtl/afd_front.sv
// Front end: accepts requests, tracks the time of the last byte and classifies each request.
// Depends on afd_pkg.
module afd_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  logic                queue_ready,
    input  logic                req_type,
    input  logic [7:0]          rx_byte,
    input  logic [31:0]         now_ms,
    input  logic [15:0]         quiet_timeout_ms,
    input  logic [31:0]         link_worry_ms,
    output logic                push,
    output afd_pkg::afd_item_t  item
);

    logic [31:0] last_byte_time_reg;
    logic [31:0] last_byte_time_next;
    logic [31:0] gap_ms;

    assign push   = in_valid && queue_ready;
    assign gap_ms = now_ms - last_byte_time_reg;

    always_comb begin
        item.is_byte      = !req_type;
        item.rx_byte      = rx_byte;
        item.now_ms       = now_ms;
        item.gap          = gap_ms >= {16'd0, quiet_timeout_ms};
        item.is_delim     = rx_byte == afd_pkg::DELIM_BYTE;
        item.is_type      = rx_byte == afd_pkg::TYPE_IO;
        item.is_one       = rx_byte == afd_pkg::IO_ON;
        item.now_lt_worry = now_ms < link_worry_ms;
    end

    // Status queries leave the byte clock alone.
    always_comb begin
        last_byte_time_next = last_byte_time_reg;
        if (push && !req_type) begin
            last_byte_time_next = now_ms;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_byte_time_reg <= 32'd0;
        end else begin
            last_byte_time_reg <= last_byte_time_next;
        end
    end

endmodule

>>> rtl/afd_queue.sv
// Short first-in first-out queue of classified requests between front and back end.
// Depends on afd_pkg for the item type.
module afd_queue #(
    parameter int DEPTH = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  afd_pkg::afd_item_t  push_item,
    output logic                push_ready,
    input  logic                pop,
    output logic                pop_valid,
    output afd_pkg::afd_item_t  pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    afd_pkg::afd_item_t mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef SYNTHESIS
    a_pop_needs_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0)
        else $error("queue popped while empty");
`endif

endmodule

>>> rtl/afd_back.sv
// Back end: frame parser state machine, checksum, alarm and link watchdog, output register.
// Depends on afd_pkg.
module afd_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_valid,
    input  afd_pkg::afd_item_t  item,
    output logic                pop,
    input  logic [31:0]         link_worry_ms,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [3:0]          out_data
);

    afd_pkg::phase_t phase_reg, phase_next, ph_eff;
    logic [7:0]  byte_pos_reg, byte_pos_next, pos;
    logic [15:0] frame_len_reg, frame_len_next;
    logic [7:0]  len_high_reg, len_high_next;
    logic [7:0]  running_sum_reg, running_sum_next;
    logic        type_match_reg, type_match_next;
    logic        io_active_reg, io_active_next;
    logic [31:0] last_good_reg, last_good_next;
    logic        out_valid_reg;
    logic [3:0]  out_data_reg, out_data_next;
    logic        fire, restart, data_end, good, bad, ack, link_up;
    logic [7:0]  sum_add;
    logic [31:0] link_limit;

    assign pop       = item_valid && (!out_valid_reg || out_ready);
    assign fire      = pop && item.is_byte;
    assign restart   = item.gap || (byte_pos_reg >= 8'(afd_pkg::BUFFER_BYTES));
    assign ph_eff    = restart ? afd_pkg::PH_SEEK : phase_reg;
    assign pos       = restart ? 8'd0 : byte_pos_reg;
    assign data_end  = ({8'd0, pos} - 16'd2) >= frame_len_reg;
    assign sum_add   = running_sum_reg + item.rx_byte;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb begin
        phase_next = phase_reg;
        if (fire) begin
            unique case (ph_eff)
                afd_pkg::PH_SEEK: phase_next = item.is_delim ? afd_pkg::PH_SIZE : afd_pkg::PH_SEEK;
                afd_pkg::PH_SIZE: phase_next = (pos >= 8'd2) ? afd_pkg::PH_DATA : afd_pkg::PH_SIZE;
                afd_pkg::PH_DATA: phase_next = data_end ? afd_pkg::PH_CKSM : afd_pkg::PH_DATA;
                afd_pkg::PH_CKSM: phase_next = afd_pkg::PH_SEEK;
            endcase
        end
    end

    always_comb begin
        byte_pos_next    = byte_pos_reg;
        frame_len_next   = frame_len_reg;
        len_high_next    = len_high_reg;
        running_sum_next = running_sum_reg;
        type_match_next  = type_match_reg;
        io_active_next   = io_active_reg;
        last_good_next   = last_good_reg;
        good = 1'b0;
        bad  = 1'b0;
        ack  = 1'b0;
        if (fire) begin
            byte_pos_next = pos + 8'd1;
            if (pos == 8'(afd_pkg::IO_BYTE_POS) &&
                (ph_eff == afd_pkg::PH_DATA || ph_eff == afd_pkg::PH_CKSM)) begin
                io_active_next = item.is_one;
            end
            unique case (ph_eff)
                afd_pkg::PH_SEEK: begin
                    if (item.is_delim) begin
                        byte_pos_next    = 8'd1;
                        running_sum_next = 8'd0;
                        type_match_next  = 1'b0;
                        io_active_next   = 1'b0;
                    end else begin
                        byte_pos_next = 8'd0;
                    end
                end
                afd_pkg::PH_SIZE: begin
                    if (pos >= 8'd2) begin
                        frame_len_next = {len_high_reg, item.rx_byte};
                    end else begin
                        len_high_next = item.rx_byte;
                    end
                end
                afd_pkg::PH_DATA: begin
                    running_sum_next = sum_add;
                    if (pos == 8'd3) begin
                        type_match_next = item.is_type;
                    end
                end
                afd_pkg::PH_CKSM: begin
                    running_sum_next = sum_add;
                    byte_pos_next    = 8'd0;
                    if (sum_add == afd_pkg::SUM_GOOD) begin
                        good           = 1'b1;
                        last_good_next = item.now_ms;
                        ack            = type_match_reg && io_active_next;
                    end else begin
                        bad = 1'b1;
                    end
                end
            endcase
        end
        link_limit    = last_good_next + link_worry_ms;
        link_up       = item.now_lt_worry || (link_limit > item.now_ms);
        out_data_next = {link_up, ack, bad, good};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= afd_pkg::PH_SEEK;
            byte_pos_reg    <= 8'd0;
            frame_len_reg   <= 16'd0;
            len_high_reg    <= 8'd0;
            running_sum_reg <= 8'd0;
            type_match_reg  <= 1'b0;
            io_active_reg   <= 1'b0;
            last_good_reg   <= 32'd0;
            out_valid_reg   <= 1'b0;
        end else begin
            phase_reg       <= phase_next;
            byte_pos_reg    <= byte_pos_next;
            frame_len_reg   <= frame_len_next;
            len_high_reg    <= len_high_next;
            running_sum_reg <= running_sum_next;
            type_match_reg  <= type_match_next;
            io_active_reg   <= io_active_next;
            last_good_reg   <= last_good_next;
            if (pop) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_data_reg <= out_data_next;
        end
    end

`ifndef SYNTHESIS
    a_seek_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == afd_pkg::PH_SEEK) == (byte_pos_reg == 8'd0))
        else $error("byte position out of step with parser phase");

    a_ack_only_good: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_data_reg[2]) |-> (out_data_reg[0] && !out_data_reg[1]))
        else $error("alarm acknowledge without a good frame");

    a_good_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && ph_eff == afd_pkg::PH_CKSM && good) |=>
        (last_good_reg == $past(item.now_ms) && phase_reg == afd_pkg::PH_SEEK))
        else $error("good frame did not record its time or restart the hunt");
`endif

endmodule

>>> test/testbench.sv
// Self-checking testbench for the delimiter, length and checksum frame deframer.
// Depends on afd_pkg and api_frame_deframer_checksum; a frame status board predicts
// each result; plain tasks drive the request and register channels, a process the results.
module testbench;
    import afd_pkg::*;

    // Position of the first data byte within a frame: delimiter, then two length bytes.
    localparam int FIRST_DATA_POS = 3;
    localparam int SEG_ITEMS      = 120;
    localparam int SEG_COUNT      = 6;

    // The four status flags in m_tdata order, lowest bit last.
    typedef struct packed {
        logic link_up;
        logic alarm_ack;
        logic frame_bad;
        logic frame_good;
    } frame_status_t;

    // Shadow of the deframer: its registers, its parser state and the statuses it owes.
    class frame_status_board;
        logic [15:0]   quiet_ms;
        logic [31:0]   worry_ms;
        phase_t        parse_phase;
        logic [7:0]    frame_pos;
        logic [15:0]   body_len;
        logic [7:0]    len_hi;
        logic [7:0]    data_sum;
        bit            type_seen;
        bit            io_seen;
        logic [31:0]   last_rx_ms;
        logic [31:0]   last_good_ms;
        frame_status_t pending_status[$];
        int            mismatches;

        function new();
            quiet_ms     = 16'd10;
            worry_ms     = 32'd150000;
            parse_phase  = PH_SEEK;
            frame_pos    = '0;
            body_len     = '0;
            len_hi       = '0;
            data_sum     = '0;
            type_seen    = 1'b0;
            io_seen      = 1'b0;
            last_rx_ms   = '0;
            last_good_ms = '0;
            mismatches   = 0;
        endfunction

        function void write_reg(logic [1:0] index, logic [31:0] value);
            if (index == CFG_QUIET_TIMEOUT) begin
                quiet_ms = value[15:0];
            end else if (index == CFG_LINK_WORRY) begin
                worry_ms = value;
            end
        endfunction

        // Advance the parser by one accepted request and queue the status it must produce.
        function void note_request(bit is_query, logic [7:0] rx, logic [31:0] stamp);
            frame_status_t res;
            logic [7:0]    this_pos;
            logic [31:0]   horizon;
            res = '0;
            if (!is_query) begin
                // A full buffer or a quiet gap abandons whatever frame was in progress.
                if (int'(frame_pos) >= BUFFER_BYTES ||
                    stamp - last_rx_ms >= {16'd0, quiet_ms}) begin
                    parse_phase = PH_SEEK;
                    frame_pos   = '0;
                end
                last_rx_ms = stamp;
                this_pos   = frame_pos;
                frame_pos  = this_pos + 8'd1;
                // The input byte counts only once the frame has reached its data, and the
                // checksum byte may itself sit at that position.
                if (int'(this_pos) == IO_BYTE_POS && parse_phase >= PH_DATA) begin
                    io_seen = (rx == IO_ON);
                end
                case (parse_phase)
                    PH_SEEK: begin
                        if (rx == DELIM_BYTE) begin
                            parse_phase = PH_SIZE;
                            frame_pos   = 8'd1;
                            data_sum    = '0;
                            type_seen   = 1'b0;
                            io_seen     = 1'b0;
                        end else begin
                            frame_pos = '0;
                        end
                    end
                    PH_SIZE: begin
                        if (int'(frame_pos) >= FIRST_DATA_POS) begin
                            body_len    = {len_hi, rx};
                            parse_phase = PH_DATA;
                        end else begin
                            len_hi = rx;
                        end
                    end
                    PH_DATA: begin
                        data_sum = data_sum + rx;
                        if (int'(this_pos) == FIRST_DATA_POS) begin
                            type_seen = (rx == TYPE_IO);
                        end
                        // A zero length still carries one data byte.
                        if (int'(frame_pos) - FIRST_DATA_POS >= int'(body_len)) begin
                            parse_phase = PH_CKSM;
                        end
                    end
                    default: begin
                        data_sum = data_sum + rx;
                        if (data_sum == SUM_GOOD) begin
                            res.frame_good = 1'b1;
                            last_good_ms   = stamp;
                            res.alarm_ack  = type_seen && io_seen;
                        end else begin
                            res.frame_bad = 1'b1;
                        end
                        parse_phase = PH_SEEK;
                        frame_pos   = '0;
                    end
                endcase
            end
            horizon     = last_good_ms + worry_ms;
            res.link_up = (stamp < worry_ms) || (horizon > stamp);
            pending_status.push_back(res);
        endfunction

        function void note_mismatch(string what, frame_status_t want, logic [7:0] got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: %s: expected good=%0b bad=%0b ack=%0b link=%0b, got %h",
                         $time, what, want.frame_good, want.frame_bad, want.alarm_ack,
                         want.link_up, got);
            end
        endfunction

        function void check_status(logic [7:0] got);
            frame_status_t want;
            if (pending_status.size() == 0) begin
                note_mismatch("result with nothing outstanding", '0, got);
                return;
            end
            want = pending_status.pop_front();
            if (got[0] !== want.frame_good || got[1] !== want.frame_bad ||
                got[2] !== want.alarm_ack || got[3] !== want.link_up || got[7:4] !== 4'd0) begin
                note_mismatch("status mismatch", want, got);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = '0;    // rx_byte [7:0], now_ms [39:8]
    logic        s_tuser   = 1'b0;  // req_type [0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;           // frame_good [0], frame_bad [1], alarm_ack [2], link_up [3]
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_QUIET_TIMEOUT;
    logic [31:0] cfg_data  = '0;

    frame_status_board board;
    int unsigned       sender_idle_pct   = 0;
    int unsigned       receiver_idle_pct = 0;
    int unsigned       item_count        = 0;
    logic [31:0]       clock_ms          = '0;

    api_frame_deframer_checksum dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Result side: values are sampled as they stood at the edge, and the ready for the
    // next cycle is chosen at random according to the current stall rate.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                board.check_status(m_tdata);
            end
            m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // Offer one request, after a random number of idle cycles, and hold it until taken.
    task automatic send_request(input bit is_query, input logic [7:0] rx,
                                input logic [31:0] stamp);
        int unsigned gap_cycles;
        gap_cycles = 0;
        while ($urandom_range(0, 99) < sender_idle_pct) gap_cycles++;
        if (gap_cycles != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap_cycles) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {stamp, rx};
        s_tuser  <= is_query;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_request(is_query, rx, stamp);
        item_count++;
    endtask

    // Hold off new requests until every outstanding status has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (board.pending_status.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board.write_reg(index, value);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Send count bytes of a run at one timestamp, the highest byte first.
    task automatic send_run(input logic [39:0] run, input int count, input logic [31:0] stamp);
        for (int i = count - 1; i >= 0; i--) begin
            send_request(1'b0, run[8*i +: 8], stamp);
        end
    endtask

    // Move the millisecond clock on. Inside a frame a gap long enough to restart the hunt
    // is rare; between frames gaps, exact timeout boundaries and wild jumps are common.
    function automatic logic [31:0] step_clock(input bit keep_frame);
        int unsigned roll;
        int unsigned limit;
        roll  = $urandom_range(0, 99);
        limit = board.quiet_ms;
        if (roll >= (keep_frame ? 99 : 90)) begin
            clock_ms += $urandom;
        end else if (roll >= (keep_frame ? 97 : 75)) begin
            clock_ms += limit - $urandom_range(0, 1);
        end else if (roll >= (keep_frame ? 60 : 40)) begin
            clock_ms += $urandom_range(0, limit - 1);
        end
        return clock_ms;
    endfunction

    // One well-formed frame with random content, now and then cut short or given a bad
    // checksum, with status queries scattered between its bytes.
    task automatic send_frame();
        logic [7:0]  wire_bytes[$];
        logic [7:0]  data_sum;
        logic [15:0] len_field;
        int          data_count;
        int          cut_at;
        int          roll;
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            // Long frames, most of which run past the buffer.
            len_field  = 16'($urandom_range(121, 65535));
            data_count = (len_field < 16'd130) ? int'(len_field) : int'($urandom_range(121, 130));
        end else if (roll < 8) begin
            len_field  = 16'd0;
            data_count = 1;
        end else if (roll < 20) begin
            // The checksum byte lands on the input byte position.
            len_field  = 16'(IO_BYTE_POS - FIRST_DATA_POS);
            data_count = IO_BYTE_POS - FIRST_DATA_POS;
        end else if (roll < 60) begin
            data_count = $urandom_range(IO_BYTE_POS - FIRST_DATA_POS + 1, 30);
            len_field  = 16'(data_count);
        end else begin
            data_count = $urandom_range(1, IO_BYTE_POS - FIRST_DATA_POS - 1);
            len_field  = 16'(data_count);
        end
        data_sum = '0;
        wire_bytes.push_back(DELIM_BYTE);
        wire_bytes.push_back(len_field[15:8]);
        wire_bytes.push_back(len_field[7:0]);
        for (int i = 0; i < data_count; i++) begin
            logic [7:0] d;
            d = 8'($urandom);
            if (i == 0 && $urandom_range(0, 1) == 1) d = TYPE_IO;
            if (i == IO_BYTE_POS - FIRST_DATA_POS && $urandom_range(0, 1) == 1) d = IO_ON;
            wire_bytes.push_back(d);
            data_sum += d;
        end
        // Bend the last data byte so that a good checksum equals the active input value.
        if (data_count == IO_BYTE_POS - FIRST_DATA_POS && wire_bytes[FIRST_DATA_POS] == TYPE_IO &&
            $urandom_range(0, 1) == 1) begin
            wire_bytes[wire_bytes.size() - 1] += SUM_GOOD - IO_ON - data_sum;
            data_sum = SUM_GOOD - IO_ON;
        end
        wire_bytes.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'(SUM_GOOD - data_sum));

        cut_at = wire_bytes.size();
        if ($urandom_range(0, 9) == 0) cut_at = $urandom_range(1, wire_bytes.size() - 1);
        for (int i = 0; i < cut_at; i++) begin
            if ($urandom_range(0, 99) < 8) send_request(1'b1, 8'($urandom), step_clock(1'b1));
            send_request(1'b0, wire_bytes[i], step_clock(i != 0));
        end
        if (cut_at != wire_bytes.size() && $urandom_range(0, 1) == 1) begin
            clock_ms += board.quiet_ms + $urandom_range(0, 50);
        end
    endtask

    task automatic send_noise();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
            send_request(1'b1, 8'($urandom), step_clock(1'b0));
        end else if (roll < 50) begin
            send_request(1'b0, DELIM_BYTE, step_clock(1'b0));
        end else begin
            send_request(1'b0, 8'($urandom), step_clock(1'b0));
        end
    endtask

    initial begin
        int unsigned seg_start;
        bit          paused;
        logic [15:0] quiet;
        logic [31:0] worry;
        board = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed requests at the reset register values.
        send_request(1'b1, 8'hFF, 32'd0);               // query inside the start grace
        send_request(1'b0, 8'h00, 32'd0);               // stray byte while hunting
        send_run(40'h7E_0000_5AA5, 5, 32'd0);           // zero length, good sum
        send_run(40'h7E_0001_1000, 5, 32'd0);           // wrong sum
        send_run(40'h7E_0002_33, 4, 32'd0);             // cut off by the quiet gap below
        send_run(40'h7E_0001_FF00, 5, 32'd10);          // delimiter right at the timeout
        send_request(1'b1, 8'h00, 32'hFFFF_FFFF);       // link reported down
        send_request(1'b0, 8'hFF, 32'hFFFF_FFFF);       // huge gap restarts the hunt
        send_request(1'b1, 8'hFF, 32'd0);               // time wrapped back into the grace
        clock_ms = '0;

        for (int seg = 0; seg < SEG_COUNT; seg++) begin
            wait_drained();
            case (seg)
                0: begin
                    quiet = 16'd1;
                    worry = 32'd1;
                end
                1: begin
                    quiet = 16'hFFFF;
                    worry = 32'hFFFF_FFFF;
                end
                2: begin
                    quiet = 16'($urandom_range(2, 50));
                    worry = $urandom_range(1, 5000);
                end
                3: begin
                    quiet = 16'd10;
                    worry = 32'd150000;
                end
                4: begin
                    quiet = 16'($urandom_range(2, 1000));
                    worry = $urandom_range(1, 32'hFFFF_FFFF);
                end
                default: begin
                    quiet = 16'd3;
                    worry = 32'd200;
                end
            endcase
            write_reg(CFG_QUIET_TIMEOUT, {16'd0, quiet});
            write_reg(CFG_LINK_WORRY, worry);
            sender_idle_pct   = (seg < 2) ? 32 : (seg < 4) ? 84 : 0;
            receiver_idle_pct = (seg < 2) ? 84 : (seg < 4) ? 32 : 0;

            seg_start = item_count;
            paused    = 1'b0;
            while (item_count - seg_start < SEG_ITEMS) begin
                if (!paused && item_count - seg_start >= SEG_ITEMS / 2) begin
                    wait_drained();
                    paused = 1'b1;
                end
                if ($urandom_range(0, 99) < 75) begin
                    send_frame();
                end else begin
                    repeat ($urandom_range(1, 4)) send_noise();
                end
            end
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        if (board.mismatches == 0 && board.pending_status.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Give up if the run hangs.
    initial begin
        #5000000;
        $display("Verification failed");
        $finish;
    end
endmodule
